>>> rtl/core/pbsm_pkg.sv
// Package with table sizes, entry layouts, function codes and sequencer states of the mapper.
package pbsm_pkg;

    localparam int CPX_ENTRIES  = 4;
    localparam int PORT_ENTRIES = 16;
    localparam int MAP_ENTRIES  = 32;

    localparam int CPX_AW  = (CPX_ENTRIES > 1) ? $clog2(CPX_ENTRIES) : 1;
    localparam int PORT_AW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int MAP_AW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    localparam int MAX_ENTRIES_A = (CPX_ENTRIES > PORT_ENTRIES) ? CPX_ENTRIES : PORT_ENTRIES;
    localparam int MAX_ENTRIES   = (MAX_ENTRIES_A > MAP_ENTRIES) ? MAX_ENTRIES_A : MAP_ENTRIES;
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);

    localparam int OFFSET_SHIFT = 16;
    localparam int ECAM_W       = 64;
    localparam int PORT_W       = 18;
    localparam int MAP_W        = 58;

    typedef enum logic [2:0] {
        FN_WR_CPX    = 3'd0,
        FN_WR_PORT   = 3'd1,
        FN_WR_MAP    = 3'd2,
        FN_TRANSLATE = 3'd3,
        FN_PORT_CHK  = 3'd4,
        FN_MAX_ID    = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CPX,
        S_PORT,
        S_MAP,
        S_DONE
    } t_state;

endpackage

>>> rtl/core/pbsm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pcie_bdf_to_stream_id_mapper.sv
// Top level of the PCIe BDF to SMMU stream id mapper: table RAMs and scan sequencer.
// A write word goes straight to the result register; a port check scans the complex and
// port tables, a translate the complex, port and mapping tables, a max id query the port
// and mapping tables, each entry by entry, and then the result register is loaded.
// One word is in work at a time; the next is taken the cycle after the result is loaded,
// and a stalled result holds the sequencer. Reset clears all valid bits and the sequencer.
module pcie_bdf_to_stream_id_mapper
    import pbsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_slot,
    input  logic        i_entry_valid,
    input  logic [1:0]  i_owner_complex,
    input  logic [63:0] i_ecam_address,
    input  logic [15:0] i_bdf_value,
    input  logic [15:0] i_port_id,
    input  logic [15:0] i_range_base,
    input  logic [15:0] i_range_top,
    input  logic [15:0] i_range_offset,
    input  logic [7:0]  i_smmu_select,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic        o_ecam_known,
    output logic [7:0]  o_smmu_index,
    output logic [31:0] o_stream_id
);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]        r_cnt;
    logic                    r_pv;
    logic [CNT_W-1:0]        r_pidx;
    logic [CPX_ENTRIES-1:0]  r_cvalid;
    logic [PORT_ENTRIES-1:0] r_pvalid;
    logic [MAP_ENTRIES-1:0]  r_mvalid;

    t_func       r_func;
    logic [63:0] r_ecam;
    logic [15:0] r_bdf;
    logic [15:0] r_pid;
    logic [7:0]  r_smmu;

    logic                   r_cfound;
    logic [CPX_AW-1:0]      r_cidx;
    logic [CPX_ENTRIES-1:0] r_has;
    logic                   r_pidmatch;
    logic                   r_hit;
    logic                   r_bad;
    logic                   r_found;
    logic [31:0]            r_best;

    logic        r_res_status;
    logic        r_res_known;
    logic [7:0]  r_res_sidx;
    logic [31:0] r_res_sid;

    logic        r_out_valid;
    logic        r_status;
    logic        r_known;
    logic [7:0]  r_sidx;
    logic [31:0] r_sid;

    logic             in_acc;
    t_func            in_func;
    logic [CNT_W-1:0] limit;
    logic             scanning;
    logic             issue;
    logic             scan_end;
    logic             slot_ok;

    logic [ECAM_W-1:0] cpx_rdata;
    logic [PORT_W-1:0] port_rdata;
    logic [MAP_W-1:0]  map_rdata;
    logic              cpx_we;
    logic              port_we;
    logic              map_we;

    logic [1:0]  p_owner;
    logic [15:0] p_id;
    logic [1:0]  m_owner;
    logic [15:0] m_base;
    logic [15:0] m_top;
    logic [15:0] m_off;
    logic [7:0]  m_smmu;
    logic [31:0] m_sid;
    logic [31:0] m_tmax;
    logic        m_owner_ok;
    logic        p_owner_ok;
    logic        bad_all;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_func    = t_func'(i_func);

    always_comb begin
        case (in_func)
            FN_WR_CPX:  slot_ok = 32'(i_slot) < CPX_ENTRIES;
            FN_WR_PORT: slot_ok = 32'(i_slot) < PORT_ENTRIES;
            FN_WR_MAP:  slot_ok = 32'(i_slot) < MAP_ENTRIES;
            default:    slot_ok = 1'b0;
        endcase
    end

    assign cpx_we  = in_acc && (in_func == FN_WR_CPX) && slot_ok;
    assign port_we = in_acc && (in_func == FN_WR_PORT) && slot_ok;
    assign map_we  = in_acc && (in_func == FN_WR_MAP) && slot_ok;

    pbsm_ram #(.WIDTH(ECAM_W), .DEPTH(CPX_ENTRIES)) u_cpx_ram (
        .i_clk   (i_clk),
        .i_we    (cpx_we),
        .i_waddr (CPX_AW'(i_slot)),
        .i_wdata (i_ecam_address),
        .i_raddr (r_cnt[CPX_AW-1:0]),
        .o_rdata (cpx_rdata)
    );

    pbsm_ram #(.WIDTH(PORT_W), .DEPTH(PORT_ENTRIES)) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (port_we),
        .i_waddr (PORT_AW'(i_slot)),
        .i_wdata ({i_owner_complex, i_port_id}),
        .i_raddr (r_cnt[PORT_AW-1:0]),
        .o_rdata (port_rdata)
    );

    pbsm_ram #(.WIDTH(MAP_W), .DEPTH(MAP_ENTRIES)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (MAP_AW'(i_slot)),
        .i_wdata ({i_owner_complex, i_range_base, i_range_top, i_range_offset,
                   i_smmu_select}),
        .i_raddr (r_cnt[MAP_AW-1:0]),
        .o_rdata (map_rdata)
    );

    assign p_owner    = port_rdata[17:16];
    assign p_id       = port_rdata[15:0];
    assign m_owner    = map_rdata[57:56];
    assign m_base     = map_rdata[55:40];
    assign m_top      = map_rdata[39:24];
    assign m_off      = map_rdata[23:8];
    assign m_smmu     = map_rdata[7:0];
    assign m_sid      = {m_off, 16'h0000} + {16'h0000, r_bdf};
    assign m_tmax     = {m_off, 16'h0000} + {16'h0000, m_top};
    assign p_owner_ok = 32'(p_owner) < CPX_ENTRIES;
    assign m_owner_ok = (32'(m_owner) < CPX_ENTRIES) && r_cvalid[CPX_AW'(m_owner)];
    assign bad_all    = r_bad || (|(r_cvalid & ~r_has));

    always_comb begin
        n_state  = r_state;
        limit    = '0;
        scanning = 1'b0;
        case (r_state)
            S_CPX: begin
                limit    = CNT_W'(CPX_ENTRIES);
                scanning = 1'b1;
            end
            S_PORT: begin
                limit    = CNT_W'(PORT_ENTRIES);
                scanning = 1'b1;
            end
            S_MAP: begin
                limit    = CNT_W'(MAP_ENTRIES);
                scanning = 1'b1;
            end
            default: begin
                limit    = '0;
                scanning = 1'b0;
            end
        endcase
        issue    = scanning && (r_cnt < limit);
        scan_end = scanning && (r_cnt == limit) && !r_pv;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_func)
                        FN_TRANSLATE: n_state = S_CPX;
                        FN_PORT_CHK:  n_state = S_CPX;
                        FN_MAX_ID:    n_state = S_PORT;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_CPX: begin
                if (scan_end) begin
                    n_state = r_cfound ? S_PORT : S_DONE;
                end
            end
            S_PORT: begin
                if (scan_end) begin
                    if (r_func == FN_PORT_CHK) begin
                        n_state = S_DONE;
                    end else if (r_func == FN_TRANSLATE && !r_has[r_cidx]) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MAP;
                    end
                end
            end
            S_MAP: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_cvalid    <= '0;
            r_pvalid    <= '0;
            r_mvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (cpx_we) begin
                r_cvalid[CPX_AW'(i_slot)] <= i_entry_valid;
            end
            if (port_we) begin
                r_pvalid[PORT_AW'(i_slot)] <= i_entry_valid;
            end
            if (map_we) begin
                r_mvalid[MAP_AW'(i_slot)] <= i_entry_valid;
            end
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt;
        if (in_acc) begin
            r_func       <= in_func;
            r_ecam       <= i_ecam_address;
            r_bdf        <= i_bdf_value;
            r_pid        <= i_port_id;
            r_smmu       <= i_smmu_select;
            r_cfound     <= 1'b0;
            r_cidx       <= '0;
            r_has        <= '0;
            r_pidmatch   <= 1'b0;
            r_hit        <= 1'b0;
            r_bad        <= 1'b0;
            r_found      <= 1'b0;
            r_best       <= '0;
            r_res_status <= !slot_ok;
            r_res_known  <= 1'b0;
            r_res_sidx   <= '0;
            r_res_sid    <= '0;
        end
        case (r_state)
            S_CPX: begin
                if (r_pv && r_cvalid[r_pidx[CPX_AW-1:0]] && cpx_rdata == r_ecam && !r_cfound) begin
                    r_cfound <= 1'b1;
                    r_cidx   <= r_pidx[CPX_AW-1:0];
                end
                if (scan_end && r_cfound) begin
                    r_res_known <= 1'b1;
                end
            end
            S_PORT: begin
                if (r_pv && r_pvalid[r_pidx[PORT_AW-1:0]] && p_owner_ok) begin
                    r_has[CPX_AW'(p_owner)] <= 1'b1;
                    if (32'(p_owner) == 32'(r_cidx) && p_id == r_pid) begin
                        r_pidmatch <= 1'b1;
                    end
                end
                if (scan_end && r_func == FN_PORT_CHK) begin
                    r_res_status <= !r_pidmatch;
                end
            end
            S_MAP: begin
                if (r_pv && r_mvalid[r_pidx[MAP_AW-1:0]]) begin
                    if (r_func == FN_TRANSLATE) begin
                        if (32'(m_owner) == 32'(r_cidx) && r_bdf >= m_base && r_bdf <= m_top
                            && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_res_sidx <= m_smmu;
                            r_res_sid  <= m_sid;
                        end
                    end else if (m_owner_ok) begin
                        if (m_base > m_top) begin
                            r_bad <= 1'b1;
                        end else if (m_smmu == r_smmu) begin
                            r_found <= 1'b1;
                            if (m_tmax > r_best) begin
                                r_best <= m_tmax;
                            end
                        end
                    end
                end
                if (scan_end) begin
                    if (r_func == FN_TRANSLATE) begin
                        r_res_status <= !r_hit;
                    end else begin
                        r_res_status <= bad_all || !r_found;
                        r_res_sid    <= (bad_all || !r_found) ? 32'h0 : r_best;
                    end
                end
            end
            default: begin
            end
        endcase
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_status <= r_res_status;
            r_known  <= r_res_known;
            r_sidx   <= r_res_sidx;
            r_sid    <= r_res_sid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_ecam_known = r_known;
    assign o_smmu_index = r_sidx;
    assign o_stream_id  = r_sid;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("A second word was taken while one is in work.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) |-> (r_cnt <= CNT_W'(MAP_ENTRIES)))
        else $error("Mapping scan counter ran past the table.");

    a_map_needs_cpx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP && r_func == FN_TRANSLATE) |-> r_cfound)
        else $error("Translate reached the mapping scan without a complex.");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> o_out_valid)
        else $error("Result was not presented after completion.");

endmodule
